@@ rtl/ppt_pkg.sv @@
// Pulse-period tachometer: shared widths, operation and register codes,
// divider status type and the RPM scaling helper. No dependencies.
package ppt_pkg;

  localparam int unsigned TICK_W     = 20;  // tick_rate_hz
  localparam int unsigned STEP_W     = 32;  // overflow_step
  localparam int unsigned CNT_W      = 16;  // timer_count field
  localparam int unsigned ACC_W      = 32;  // accumulator and period slots
  localparam int unsigned SUM_W      = ACC_W + 1;
  localparam int unsigned DVD_W      = TICK_W + 7;  // 120 * tick rate
  localparam int unsigned RPM_W      = 26;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DVD_W);

  localparam logic [TICK_W-1:0] TICK_RATE_RST = TICK_W'(10000);
  localparam logic [STEP_W-1:0] OVF_STEP_RST  = STEP_W'(65535);

  typedef enum logic [OP_W-1:0] {
    OP_EDGE     = 2'd0,
    OP_OVERFLOW = 2'd1,
    OP_READ     = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_RATE = 1'b0,
    REG_OVF_STEP  = 1'b1
  } reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // 120 * tick = 128 * tick - 8 * tick
  function automatic logic [DVD_W-1:0] scale_rpm(input logic [TICK_W-1:0] tick);
    logic [DVD_W-1:0] hi;
    logic [DVD_W-1:0] lo;
    hi = {tick, 7'b0};
    lo = {4'b0, tick, 3'b0};
    return hi - lo;
  endfunction

endpackage

@@ rtl/ppt_if.sv @@
// Pulse-period tachometer channel interfaces: input request, result and
// configuration write. Depends on ppt_pkg for field widths.
interface ppt_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppt_pkg::OP_W-1:0]      operation;
  logic [ppt_pkg::CNT_W-1:0]     timer_count;

  modport source (output valid, operation, timer_count, input ready);
  modport sink   (input valid, operation, timer_count, output ready);
endinterface

interface ppt_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppt_pkg::RPM_W-1:0]     rpm;
  logic                          measured;

  modport source (output valid, rpm, measured, input ready);
  modport sink   (input valid, rpm, measured, output ready);
endinterface

interface ppt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppt_pkg::CFG_IDX_W-1:0]   index;
  logic [ppt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/ppt_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ppt_pkg for widths and the status struct.
module ppt_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ppt_pkg::DVD_W-1:0] dividend_i,
  input  logic [ppt_pkg::SUM_W-1:0] divisor_i,
  output ppt_pkg::div_stat_t       stat_o,
  output logic [ppt_pkg::DVD_W-1:0] quotient_o
);
  import ppt_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0]     quo_q;
  logic [SUM_W-1:0]     rem_q;
  logic [SUM_W-1:0]     dvs_q;

  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract where it fits
      rem_q <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finishing step");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("partial remainder not below divisor");

endmodule

@@ rtl/pulse_period_tachometer.sv @@
// Pulse-period tachometer top level: period capture, slot state, read sequencer.
// Depends on ppt_pkg, the ppt_*_if interfaces and ppt_divider.
//
//   channel   dir  payload                      accepted when
//   in_ch     in   operation, timer_count       valid && ready
//   out_ch    out  rpm, measured                valid && ready
//   cfg_ch    in   index, data                  valid && ready (always ready)
//
// Edge and overflow requests update the slot state and leave the sequencer idle.
// A read with both slots filled starts the 27-bit shared divider; its quotient
// goes to the pending register in ST_DIV, then to the output register in ST_EMIT.
// A read with an empty slot skips the divider and passes a zero result on through ST_EMIT.
// in_ch is ready only when idle.
// A result waiting on out_ch does not block new requests; a second read waits
// for the output register. Reset is asynchronous, active low; no clearing pass.
module pulse_period_tachometer #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ppt_in_if.sink    in_ch,
  ppt_out_if.source out_ch,
  ppt_cfg_if.sink   cfg_ch
);
  import ppt_pkg::*;

  localparam int unsigned CAP_W = (TIMER_BITS < CNT_W) ? TIMER_BITS : CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic                out_vld_q;
  logic [RPM_W-1:0]    out_rpm_q;
  logic                out_meas_q;
  logic [RPM_W-1:0]    pend_rpm_q;
  logic                pend_meas_q;

  logic [TICK_W-1:0]   tick_q;
  logic [STEP_W-1:0]   step_q;
  logic [CAP_W-1:0]    last_q;
  logic [ACC_W-1:0]    accum_q;
  logic [ACC_W-1:0]    slot_q [2];
  logic                ptr_q;

  op_e                 op_w;
  logic [CAP_W-1:0]    count_w;
  logic [ACC_W-1:0]    period_w;
  logic [SUM_W-1:0]    sum_w;
  logic                slots_full;
  logic                in_acc;
  logic                div_start;
  div_stat_t           div_stat;
  logic [DVD_W-1:0]    quot;

  assign op_w       = op_e'(in_ch.operation);
  assign count_w    = in_ch.timer_count[CAP_W-1:0];
  assign period_w   = ACC_W'(count_w) + accum_q - ACC_W'(last_q);
  assign sum_w      = {1'b0, slot_q[0]} + {1'b0, slot_q[1]};
  assign slots_full = (slot_q[0] != '0) && (slot_q[1] != '0);

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign div_start   = in_acc && (op_w == OP_READ) && slots_full;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TICK_RATE_RST;
      step_q <= OVF_STEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (reg_e'(cfg_ch.index))
        REG_TICK_RATE: tick_q <= cfg_ch.data[TICK_W-1:0];
        REG_OVF_STEP:  step_q <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      accum_q   <= '0;
      slot_q[0] <= '0;
      slot_q[1] <= '0;
      ptr_q     <= 1'b0;
    end else if (in_acc) begin
      unique case (op_w)
        OP_EDGE: begin
          slot_q[ptr_q] <= period_w;
          ptr_q         <= ~ptr_q;
          accum_q       <= '0;
          last_q        <= count_w;
        end
        OP_OVERFLOW: accum_q <= accum_q + step_q;
        OP_READ: begin
          // divider has latched the sum at this edge; drop both periods
          if (slots_full) begin
            slot_q[0] <= '0;
            slot_q[1] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  ppt_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scale_rpm(tick_q)),
    .divisor_i  (sum_w),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_vld_q   <= 1'b0;
      out_rpm_q   <= '0;
      out_meas_q  <= 1'b0;
      pend_rpm_q  <= '0;
      pend_meas_q <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (op_w == OP_READ)) begin
            if (slots_full) begin
              state_q <= ST_DIV;
            end else begin
              pend_rpm_q  <= '0;
              pend_meas_q <= 1'b0;
              state_q     <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            pend_rpm_q  <= quot[RPM_W-1:0];
            pend_meas_q <= 1'b1;
            state_q     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (!out_vld_q || out_ch.ready) begin
            out_vld_q  <= 1'b1;
            out_rpm_q  <= pend_rpm_q;
            out_meas_q <= pend_meas_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_vld_q;
  assign out_ch.rpm      = out_rpm_q;
  assign out_ch.measured = out_meas_q;

  a_slots_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (slot_q[0] == '0) && (slot_q[1] == '0))
    else $error("slots not cleared after measured read");

  a_unmeasured_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_meas_q |-> out_rpm_q == '0)
    else $error("nonzero rpm on unmeasured result");

  a_div_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> div_stat.busy || div_stat.done)
    else $error("sequencer waits on an idle divider");

endmodule
